[rtl/mufd_pkg.sv]
package mufd_pkg;

  // Frame layout, byte positions in transmission order
  localparam int unsigned FrameBytes = 31;
  localparam int unsigned CountSat   = 32;
  localparam int unsigned PosInst    = 3;
  localparam int unsigned PosPrice   = 7;
  localparam int unsigned PosSeq     = 15;
  localparam int unsigned PosTime    = 23;

  typedef logic [5:0] byte_cnt_t;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_SIZE       = 3'd1,
    ERR_VERSION    = 3'd2,
    ERR_EXCHANGE   = 3'd3,
    ERR_INSTRUMENT = 3'd4,
    ERR_PRICE      = 3'd5,
    ERR_SEQUENCE   = 3'd6
  } err_code_e;

  // Register indexes on the configuration port
  localparam logic [1:0] CfgProtocolVersion = 2'd0;
  localparam logic [1:0] CfgExchangeCount   = 2'd1;
  localparam logic [1:0] CfgInstrumentCount = 2'd2;

  localparam logic [7:0]  ProtocolVersionRst = 8'h01;
  localparam logic [16:0] ExchangeCountRst   = 17'h1_0000;
  localparam logic [32:0] InstrumentCountRst = 33'h1_0000_0000;

  typedef struct packed {
    logic [7:0]  protocol_version;
    logic [16:0] exch_limit;
    logic [32:0] inst_limit;
  } cfg_t;

  // One collected frame, handed from the front to the back
  typedef struct packed {
    logic        size_ok;
    logic [7:0]  version;
    logic [15:0] exchange;
    logic [31:0] instrument;
    logic [63:0] price;
    logic [63:0] sequence_num;
    logic [63:0] timestamp;
  } frame_rec_t;

endpackage

[rtl/mufd_in_if.sv]
interface mufd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

[rtl/mufd_out_if.sv]
interface mufd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  error_code;
  logic [15:0] exch_id;
  logic [31:0] inst_id;
  logic [62:0] price;
  logic [63:0] sequence_res;
  logic [63:0] timestamp_ns;

  modport source (output valid, output error_code, output exch_id, output inst_id,
                  output price, output sequence_res, output timestamp_ns, input ready);
  modport sink (input valid, input error_code, input exch_id, input inst_id,
                input price, input sequence_res, input timestamp_ns, output ready);
endinterface

[rtl/mufd_front.sv]
module mufd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mufd_in_if.sink              in_i,
  input  logic                 full_i,
  output logic                 push_o,
  output mufd_pkg::frame_rec_t rec_o
);

  mufd_pkg::byte_cnt_t count_q, count_d;
  logic [7:0]  version_q, version_d;
  logic [15:0] exch_q, exch_d;
  logic [31:0] inst_q, inst_d;
  logic [63:0] price_q, price_d;
  logic [63:0] seq_q, seq_d;
  logic [63:0] time_q, time_d;
  logic        accept;
  logic [7:0]  b;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;

  // Route the byte into the field that owns its position, MSB first
  always_comb begin
    version_d = version_q;
    exch_d    = exch_q;
    inst_d    = inst_q;
    price_d   = price_q;
    seq_d     = seq_q;
    time_d    = time_q;
    if (count_q == '0) begin
      version_d = b;
    end else if (count_q < mufd_pkg::byte_cnt_t'(mufd_pkg::PosInst)) begin
      exch_d = {exch_q[7:0], b};
    end else if (count_q < mufd_pkg::byte_cnt_t'(mufd_pkg::PosPrice)) begin
      inst_d = {inst_q[23:0], b};
    end else if (count_q < mufd_pkg::byte_cnt_t'(mufd_pkg::PosSeq)) begin
      price_d = {price_q[55:0], b};
    end else if (count_q < mufd_pkg::byte_cnt_t'(mufd_pkg::PosTime)) begin
      seq_d = {seq_q[55:0], b};
    end else if (count_q < mufd_pkg::byte_cnt_t'(mufd_pkg::FrameBytes)) begin
      time_d = {time_q[55:0], b};
    end
    if (count_q == mufd_pkg::byte_cnt_t'(mufd_pkg::CountSat)) begin
      count_d = count_q;
    end else begin
      count_d = count_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= in_i.frame_end ? '0 : count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      version_q <= version_d;
      exch_q    <= exch_d;
      inst_q    <= inst_d;
      price_q   <= price_d;
      seq_q     <= seq_d;
      time_q    <= time_d;
    end
  end

  assign push_o = accept && in_i.frame_end;

  always_comb begin
    rec_o.size_ok      = (count_q == mufd_pkg::byte_cnt_t'(mufd_pkg::FrameBytes - 1));
    rec_o.version      = version_d;
    rec_o.exchange     = exch_d;
    rec_o.instrument   = inst_d;
    rec_o.price        = price_d;
    rec_o.sequence_num = seq_d;
    rec_o.timestamp    = time_d;
  end

`ifndef SYNTHESIS
  a_count_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> count_q == '0)
    else $error("byte counter not cleared after frame end");
`endif

endmodule

[rtl/mufd_fifo.sv]
module mufd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mufd_pkg::frame_rec_t push_rec_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output mufd_pkg::frame_rec_t head_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  mufd_pkg::frame_rec_t mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("frame queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("frame queue underflow");
`endif

endmodule

[rtl/mufd_back.sv]
module mufd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mufd_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  input  mufd_pkg::frame_rec_t rec_i,
  output logic                 pop_o,
  mufd_out_if.source           out_o
);

  mufd_pkg::err_code_e err;
  logic        out_valid_q;
  logic [2:0]  err_q;
  logic [15:0] exch_q;
  logic [31:0] inst_q;
  logic [62:0] price_q;
  logic [63:0] seq_q;
  logic [63:0] time_q;
  logic        ok;

  // Checks in priority order; first failure wins
  always_comb begin
    if (!rec_i.size_ok) begin
      err = mufd_pkg::ERR_SIZE;
    end else if (rec_i.version != cfg_i.protocol_version) begin
      err = mufd_pkg::ERR_VERSION;
    end else if ({1'b0, rec_i.exchange} >= cfg_i.exch_limit) begin
      err = mufd_pkg::ERR_EXCHANGE;
    end else if ({1'b0, rec_i.instrument} >= cfg_i.inst_limit) begin
      err = mufd_pkg::ERR_INSTRUMENT;
    end else if (rec_i.price == '0 || rec_i.price[63]) begin
      err = mufd_pkg::ERR_PRICE;
    end else if (rec_i.sequence_num == '0) begin
      err = mufd_pkg::ERR_SEQUENCE;
    end else begin
      err = mufd_pkg::ERR_OK;
    end
  end

  assign ok    = (err == mufd_pkg::ERR_OK);
  assign pop_o = valid_i && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      err_q   <= err;
      exch_q  <= ok ? rec_i.exchange : '0;
      inst_q  <= ok ? rec_i.instrument : '0;
      price_q <= ok ? rec_i.price[62:0] : '0;
      seq_q   <= ok ? rec_i.sequence_num : '0;
      time_q  <= ok ? rec_i.timestamp : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.error_code   = err_q;
  assign out_o.exch_id      = exch_q;
  assign out_o.inst_id      = inst_q;
  assign out_o.price        = price_q;
  assign out_o.sequence_res = seq_q;
  assign out_o.timestamp_ns = time_q;

`ifndef SYNTHESIS
  a_err_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q != mufd_pkg::ERR_OK) |->
      (exch_q == '0 && inst_q == '0 && price_q == '0 && seq_q == '0 && time_q == '0))
    else $error("data fields not zeroed on error");
  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped frame did not reach the output register");
`endif

endmodule

[rtl/market_update_frame_decoder_unit.sv]
// Market-update frame decoder. Bytes of a 31-byte big-endian frame (version,
// 16-bit exchange id, 32-bit instrument id, 64-bit price, 64-bit sequence,
// 64-bit timestamp) enter on in_i at one byte per cycle while the queue is
// not full, with frame_end on the last byte; each frame end yields one result
// on out_o carrying an error code (0 ok, 1 size, 2 version, 3 exchange,
// 4 instrument, 5 price, 6 sequence, first failing check wins) and the
// decoded fields, all zero on error. The front collector shifts each byte
// into its field register; at frame end the collected frame goes into a
// QueueDepth-entry queue, and the back checker loads the queue head into a
// registered result once that register is empty or being transferred, so a
// frame passes the queue entry and the result register before out_o.valid
// rises. The front keeps taking bytes while results wait on out_o and stalls
// only when the queue is full. Configuration registers are written through
// cfg_we_i / cfg_idx_i / cfg_data_i (0 protocol version, 1 exchange limit,
// 2 instrument limit; index 3 is ignored) and must only be changed while no
// frame is in flight.
module market_update_frame_decoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mufd_in_if.sink     in_i,
  mufd_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [32:0] cfg_data_i
);

  mufd_pkg::cfg_t       cfg_q;
  mufd_pkg::frame_rec_t push_rec;
  mufd_pkg::frame_rec_t head_rec;
  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 head_valid;

  // Configuration registers; widths are masked by the part-selects
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protocol_version <= mufd_pkg::ProtocolVersionRst;
      cfg_q.exch_limit       <= mufd_pkg::ExchangeCountRst;
      cfg_q.inst_limit       <= mufd_pkg::InstrumentCountRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mufd_pkg::CfgProtocolVersion: cfg_q.protocol_version <= cfg_data_i[7:0];
        mufd_pkg::CfgExchangeCount:   cfg_q.exch_limit       <= cfg_data_i[16:0];
        mufd_pkg::CfgInstrumentCount: cfg_q.inst_limit       <= cfg_data_i;
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  // Front: collect bytes, hand off one record per frame
  mufd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .rec_o  (push_rec)
  );

  // Queue between the collector and the checker
  mufd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_rec)
  );

  // Back: run the checks and hold the result until transferred
  mufd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (head_valid),
    .rec_i   (head_rec),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[tb/sv/mufd_frame_checker.sv]
module mufd_frame_checker
  import mufd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mufd_in_if          byte_mon_i,
  mufd_out_if         result_mon_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [32:0] cfg_data_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    err_code_e   code;
    logic [15:0] exchange;
    logic [31:0] instrument;
    logic [62:0] price;
    logic [63:0] seq_num;
    logic [63:0] stamp;
  } decoded_t;

  // Register copies
  logic [7:0]  want_version;
  logic [16:0] exchange_limit;
  logic [32:0] instrument_limit;

  // Frame being collected
  byte_cnt_t   seen_bytes;
  logic [7:0]  version_byte;
  logic [15:0] exchange_acc;
  logic [31:0] instrument_acc;
  logic [63:0] price_acc;
  logic [63:0] sequence_acc;
  logic [63:0] timestamp_acc;

  decoded_t    frame_results[$];
  decoded_t    want;

  function automatic decoded_t close_frame();
    decoded_t res;
    res = '0;
    if (seen_bytes != FrameBytes) res.code = ERR_SIZE;
    else if (version_byte != want_version) res.code = ERR_VERSION;
    else if ({1'b0, exchange_acc} >= exchange_limit) res.code = ERR_EXCHANGE;
    else if ({1'b0, instrument_acc} >= instrument_limit) res.code = ERR_INSTRUMENT;
    else if (price_acc == '0 || price_acc[63]) res.code = ERR_PRICE;
    else if (sequence_acc == '0) res.code = ERR_SEQUENCE;
    else begin
      res.code       = ERR_OK;
      res.exchange   = exchange_acc;
      res.instrument = instrument_acc;
      res.price      = price_acc[62:0];
      res.seq_num    = sequence_acc;
      res.stamp      = timestamp_acc;
    end
    return res;
  endfunction

  task automatic clear_frame();
    seen_bytes     = '0;
    version_byte   = '0;
    exchange_acc   = '0;
    instrument_acc = '0;
    price_acc      = '0;
    sequence_acc   = '0;
    timestamp_acc  = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    if (seen_bytes == 0) version_byte = b;
    else if (seen_bytes < PosInst) exchange_acc = {exchange_acc[7:0], b};
    else if (seen_bytes < PosPrice) instrument_acc = {instrument_acc[23:0], b};
    else if (seen_bytes < PosSeq) price_acc = {price_acc[55:0], b};
    else if (seen_bytes < PosTime) sequence_acc = {sequence_acc[55:0], b};
    else if (seen_bytes < FrameBytes) timestamp_acc = {timestamp_acc[55:0], b};
    if (seen_bytes < CountSat) seen_bytes++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_version     = ProtocolVersionRst;
      exchange_limit   = ExchangeCountRst;
      instrument_limit = InstrumentCountRst;
      clear_frame();
      frame_results.delete();
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgProtocolVersion: want_version     = cfg_data_i[7:0];
          CfgExchangeCount:   exchange_limit   = cfg_data_i[16:0];
          CfgInstrumentCount: instrument_limit = cfg_data_i;
          default: ;
        endcase
      end

      if (result_mon_i.valid && result_mon_i.ready) begin
        if (frame_results.size() == 0) begin
          $error("result transfer with no frame end pending");
          error_count_o++;
        end else begin
          want = frame_results.pop_front();
          compare_field("error_code", want.code, result_mon_i.error_code);
          compare_field("exch_id", want.exchange, result_mon_i.exch_id);
          compare_field("inst_id", want.instrument, result_mon_i.inst_id);
          compare_field("price", want.price, result_mon_i.price);
          compare_field("sequence_res", want.seq_num, result_mon_i.sequence_res);
          compare_field("timestamp_ns", want.stamp, result_mon_i.timestamp_ns);
        end
      end

      if (byte_mon_i.valid && byte_mon_i.ready) begin
        absorb_byte(byte_mon_i.data_byte);
        if (byte_mon_i.frame_end) begin
          frame_results.push_back(close_frame());
          clear_frame();
        end
      end
      pending_o = frame_results.size();
    end
  end

endmodule

[tb/sv/market_update_frame_decoder_unit_tb.sv]
module market_update_frame_decoder_unit_tb;
  import mufd_pkg::*;

  // Index 3 has no register behind it; writes there must be dropped
  localparam logic [1:0]  CfgUnused     = 2'd3;
  localparam logic [63:0] PriceMax      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned PhaseBytes    = 95;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned MaxNoiseBytes = 45;

  typedef enum int unsigned {
    StallNone,
    StallCoin,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [32:0] cfg_data;

  int unsigned mismatches;
  int unsigned in_flight;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned sent;

  // Register values as last written, used to aim ids at the limits
  logic [7:0]  cur_version;
  logic [16:0] cur_exch_limit;
  logic [32:0] cur_inst_limit;

  mufd_in_if  in_bus ();
  mufd_out_if out_bus ();

  market_update_frame_decoder_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  mufd_frame_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_mon_i    (in_bus),
    .result_mon_i  (out_bus),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .error_count_o (mismatches),
    .pending_o     (in_flight)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort when neither channel moves a transfer for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side back-pressure: switch between stall styles every so often so
  // that stalls land on every phase of the decoder, with clean stretches too
  initial begin
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned tick;
    out_bus.ready = 1'b0;
    mode = StallNone;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        StallNone:  out_bus.ready <= 1'b1;
        StallCoin:  out_bus.ready <= 1'($urandom_range(0, 1));
        StallHeavy: out_bus.ready <= ($urandom_range(0, 7) == 0);
        default:    out_bus.ready <= (tick % 5 != 0);
      endcase
    end
  end

  // Offer one byte, starting and ending at a falling edge. Bytes go out in
  // bursts of random length; a random gap (sometimes none) precedes each burst.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.frame_end <= last;
    // Hold until the transfer happens
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Serialize a frame big-endian. Short lengths cut it off; bytes past the
  // timestamp are random filler that the decoder must ignore.
  task automatic send_frame(input logic [7:0] ver, input logic [15:0] exch,
                            input logic [31:0] inst, input logic [63:0] prc,
                            input logic [63:0] seqn, input logic [63:0] stamp,
                            input int unsigned len);
    logic [247:0] image;
    logic [7:0]   b;
    image = {ver, exch, inst, prc, seqn, stamp};
    for (int unsigned k = 0; k < len; k++) begin
      b = (k < FrameBytes) ? image[247 - 8 * k -: 8] : 8'($urandom);
      send_byte(b, k == len - 1);
    end
  endtask

  // Drop valid, wait for every pending result, then let the back end drain
  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(negedge clk_i); while (in_flight != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write all three registers plus the unused index. Upper data bits of the
  // version and exchange writes carry junk that the decoder must mask off.
  task automatic load_limits(input logic [7:0] ver, input logic [16:0] exch,
                             input logic [32:0] inst);
    logic [63:0] junk;
    settle();
    junk = {$urandom, $urandom};
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgProtocolVersion;
    cfg_data <= {junk[24:0], ver};
    @(negedge clk_i);
    cfg_idx  <= CfgExchangeCount;
    cfg_data <= {junk[40:25], exch};
    @(negedge clk_i);
    cfg_idx  <= CfgInstrumentCount;
    cfg_data <= inst;
    @(negedge clk_i);
    cfg_idx  <= CfgUnused;
    cfg_data <= junk[32:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    cur_version    = ver;
    cur_exch_limit = exch;
    cur_inst_limit = inst;
  endtask

  // Pick an id mostly below the limit, sometimes right at it on either side
  function automatic logic [31:0] pick_id(input logic [32:0] limit);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (limit == 0 || r == 0) return $urandom;
    if (r == 1) return 32'(limit - 1);
    if (r == 2) return 32'(limit);
    return $urandom_range(0, 32'(limit - 1));
  endfunction

  function automatic logic [63:0] pick_price();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return {1'b1, 63'({$urandom, $urandom})};
      2:       return PriceMax;
      3:       return 64'd1;
      default: return {1'b0, 63'({$urandom, $urandom})};
    endcase
  endfunction

  // One random frame: mostly well formed with random content, some cut
  // short or overlong, some pure noise
  task automatic random_frame(output int unsigned len);
    int unsigned kind;
    logic [7:0]  ver;
    logic [15:0] exch;
    logic [31:0] inst;
    logic [63:0] prc;
    logic [63:0] seqn;
    logic [63:0] stamp;
    kind  = $urandom_range(0, 19);
    ver   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_version;
    exch  = 16'(pick_id({16'b0, cur_exch_limit}));
    inst  = pick_id(cur_inst_limit);
    prc   = pick_price();
    seqn  = ($urandom_range(0, 11) == 0) ? 64'd0 : {$urandom, $urandom};
    stamp = {$urandom, $urandom};
    case (kind)
      0: begin
        ver  = 8'($urandom);
        exch = 16'($urandom);
        inst = $urandom;
        prc  = {$urandom, $urandom};
        seqn = {$urandom, $urandom};
        len  = $urandom_range(1, MaxNoiseBytes);
      end
      1:       len = $urandom_range(1, FrameBytes - 1);
      2:       len = $urandom_range(FrameBytes + 1, MaxNoiseBytes);
      default: len = FrameBytes;
    endcase
    send_frame(ver, exch, inst, prc, seqn, stamp, len);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CfgProtocolVersion;
    cfg_data         = '0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    in_bus.frame_end = 1'b0;
    burst_left       = 0;
    cur_version      = ProtocolVersionRst;
    cur_exch_limit   = ExchangeCountRst;
    cur_inst_limit   = InstrumentCountRst;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames under the reset limits
    // Largest legal value in every field
    send_frame(8'h01, 16'hFFFF, 32'hFFFF_FFFF, PriceMax, '1, '1, FrameBytes);
    // Smallest legal values
    send_frame(8'h01, 16'h0, 32'h0, 64'd1, 64'd1, 64'd0, FrameBytes);
    // Lone end marker, then a frame one byte short
    send_frame(8'h01, 16'h1, 32'h1, 64'd1, 64'd1, 64'd1, 1);
    send_frame(8'h01, 16'h1, 32'h1, 64'd1, 64'd1, 64'd1, FrameBytes - 1);
    // Overlong frame: the counter saturates, extra bytes are ignored
    send_frame(8'h01, 16'h2, 32'h2, 64'd2, 64'd2, 64'd2, MaxNoiseBytes);
    // Wrong version outranks bad price and sequence
    send_frame(8'h02, 16'h3, 32'h3, 64'd0, 64'd0, 64'd3, FrameBytes);
    // Zero price, price with the sign bit set, zero sequence
    send_frame(8'h01, 16'h4, 32'h4, 64'd0, 64'd4, 64'd4, FrameBytes);
    send_frame(8'h01, 16'h5, 32'h5, 64'h8000_0000_0000_0000, 64'd5, 64'd5, FrameBytes);
    send_frame(8'h01, 16'h6, 32'h6, 64'd6, 64'd0, 64'd6, FrameBytes);

    // Tight limits: exchange outranks price, instrument at and below its limit
    load_limits(8'h01, 17'h100, 33'h1000);
    send_frame(8'h01, 16'h0100, 32'h0, 64'd0, 64'd7, 64'd7, FrameBytes);
    send_frame(8'h01, 16'h00FF, 32'h1000, 64'd8, 64'd8, 64'd8, FrameBytes);
    send_frame(8'h01, 16'h00FF, 32'h0FFF, 64'd9, 64'd9, 64'd9, FrameBytes);

    // Random phases, each under its own register setting, extremes first
    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: load_limits(8'h00, 17'h1_0000, 33'h1_0000_0000);
        1: load_limits(8'hFF, 17'h0, 33'h0);
        2: load_limits(8'h01, 17'h1, 33'h1);
        3: load_limits(8'h80, 17'hFFFF, 33'hFFFF_FFFF);
        default: load_limits(8'($urandom), 17'($urandom_range(0, 17'h1_0000)),
                             ($urandom_range(0, 3) == 0) ? 33'h1_0000_0000
                                                         : {1'b0, $urandom});
      endcase
      sent = 0;
      while (sent < PhaseBytes) begin
        int unsigned len;
        random_frame(len);
        sent += len;
      end
    end

    // Wait out the last results, then give the verdict
    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mufd_pkg.sv
rtl/mufd_in_if.sv
rtl/mufd_out_if.sv
rtl/mufd_front.sv
rtl/mufd_fifo.sv
rtl/mufd_back.sv
rtl/market_update_frame_decoder_unit.sv
tb/sv/mufd_frame_checker.sv
tb/sv/market_update_frame_decoder_unit_tb.sv
